### src/xcpr_pkg.sv
package xcpr_pkg;

   localparam int unsigned PAYLOAD_BYTES = 128;
   localparam int unsigned FRAME_BYTES   = 133;
   localparam int unsigned WORDS         = PAYLOAD_BYTES / 4;
   localparam int unsigned WORD_IDX_W    = $clog2(WORDS);
   localparam int unsigned PAY_SHIFT     = $clog2(PAYLOAD_BYTES);

   localparam logic [7:0] LEAD_SOH   = 8'h01;
   localparam logic [7:0] LEAD_EOT   = 8'h04;
   localparam logic [7:0] DATA_FIRST = 8'd3;
   localparam logic [7:0] DATA_LAST  = 8'(3 + PAYLOAD_BYTES - 1);
   localparam logic [7:0] CRC_HI_POS = 8'(FRAME_BYTES - 2);
   localparam logic [7:0] CRC_LO_POS = 8'(FRAME_BYTES - 1);
   localparam logic [7:0] COUNT_MAX  = 8'hFF;

   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_INIT   = 16'h0000;
   localparam logic [15:0] PACKET_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_NAK  = 2'd2,
      KIND_DONE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [31:0] write_address;
      logic [31:0] write_word;
      logic [22:0] transfer_length;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic     take;
      logic     start_packet;
      logic     load;
      kind_type kind;
      logic     last;
      logic     clear_count;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic soh_end;
      logic crc_ok;
      logic eot;
      logic last_word;
   } dp_status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

### src/xcpr_datapath.sv
module xcpr_datapath
   import xcpr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic          csr_write_enable,
   input  logic [31:0]   csr_write_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic [7:0]            count_ff, count_in;
   logic [7:0]            lead_ff, lead_in;
   logic [15:0]           crc_ff, crc_in;
   logic [7:0]            crc_hi_ff, crc_hi_in;
   logic [23:0]           asm_ff, asm_in;
   logic [15:0]           pc_ff, pc_in;
   logic [31:0]           dest_ff, dest_in;
   logic [31:0]           addr_ff, addr_in;
   logic [WORD_IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]           rd_data_ff;
   logic                  valid_ff, valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [31:0]           mem [WORDS];

   logic [7:0]            pos;
   logic [7:0]            lead_cur;
   logic                  in_data;
   logic [PAY_SHIFT-1:0]  d;
   logic                  mem_we;
   logic [15:0]           base_idx;
   logic                  load_data;

   assign pos       = count_ff;
   assign lead_cur  = (pos == 8'd0) ? req_data.rx_byte : lead_ff;
   assign in_data   = (pos >= DATA_FIRST) && (pos <= DATA_LAST);
   assign d         = PAY_SHIFT'(pos - DATA_FIRST);
   assign mem_we    = cmd.take && in_data && (d[1:0] == 2'd3);
   assign base_idx  = (pc_ff < PACKET_MAX) ? pc_ff : PACKET_MAX - 16'd1;
   assign load_data = cmd.load && (cmd.kind == KIND_DATA);

   assign status.slot_free = !valid_ff || rsp_ready;
   assign status.soh_end   = (pos == CRC_LO_POS) && (lead_cur == LEAD_SOH);
   assign status.crc_ok    = ({crc_hi_ff, req_data.rx_byte} == crc_ff);
   assign status.eot       = (pos == 8'd0) && (req_data.rx_byte == LEAD_EOT);
   assign status.last_word = &idx_ff;

   always_comb begin
      count_in  = count_ff;
      lead_in   = lead_ff;
      crc_in    = crc_ff;
      crc_hi_in = crc_hi_ff;
      asm_in    = asm_ff;
      if (cmd.take) begin
         if (req_data.frame_end) begin
            count_in  = 8'd0;
            lead_in   = 8'd0;
            crc_in    = CRC_INIT;
            crc_hi_in = 8'd0;
            asm_in    = 24'd0;
         end else begin
            lead_in = lead_cur;
            if (count_ff < COUNT_MAX) begin
               count_in = count_ff + 8'd1;
            end
            if (in_data) begin
               crc_in = crc_byte(crc_ff, req_data.rx_byte);
               case (d[1:0])
                  2'd0: asm_in = {16'd0, req_data.rx_byte};
                  2'd1: asm_in[15:8] = req_data.rx_byte;
                  2'd2: asm_in[23:16] = req_data.rx_byte;
                  default: asm_in = asm_ff;
               endcase
            end else if (pos == CRC_HI_POS) begin
               crc_hi_in = req_data.rx_byte;
            end
         end
      end
   end

   always_comb begin
      pc_in   = pc_ff;
      addr_in = addr_ff;
      idx_in  = idx_ff;
      dest_in = csr_write_enable ? csr_write_data : dest_ff;
      if (cmd.start_packet) begin
         if (pc_ff < PACKET_MAX) begin
            pc_in = pc_ff + 16'd1;
         end
         addr_in = dest_ff + 32'({base_idx, {PAY_SHIFT{1'b0}}});
      end
      if (cmd.clear_count) begin
         pc_in = 16'd0;
      end
      if (load_data) begin
         addr_in = addr_ff + 32'd4;
         idx_in  = idx_ff + WORD_IDX_W'(1);
      end
   end

   always_comb begin
      rsp_in   = rsp_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.load) begin
         valid_in               = 1'b1;
         rsp_in.result_kind     = cmd.kind;
         rsp_in.write_address   = load_data ? addr_ff : 32'd0;
         rsp_in.write_word      = load_data ? rd_data_ff : 32'd0;
         rsp_in.transfer_length = (cmd.kind == KIND_DONE) ?
                                  {pc_ff, {PAY_SHIFT{1'b0}}} : 23'd0;
         rsp_in.last_result     = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 8'd0;
         lead_ff   <= 8'd0;
         crc_ff    <= CRC_INIT;
         crc_hi_ff <= 8'd0;
         asm_ff    <= 24'd0;
         pc_ff     <= 16'd0;
         dest_ff   <= 32'd0;
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         lead_ff   <= lead_in;
         crc_ff    <= crc_in;
         crc_hi_ff <= crc_hi_in;
         asm_ff    <= asm_in;
         pc_ff     <= pc_in;
         dest_ff   <= dest_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[d[2 +: WORD_IDX_W]] <= {req_data.rx_byte, asm_ff};
      end
      rd_data_ff <= mem[idx_in];
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/xcpr_ctrl.sv
module xcpr_ctrl
   import xcpr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_frame_end,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_DATA    = 6'b000010,
      S_ACK     = 6'b000100,
      S_NAK     = 6'b001000,
      S_EOT_ACK = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      take_end;

   assign req_ready = (state_ff == S_IDLE);
   assign take_end  = req_valid && req_ready && req_frame_end;

   always_comb begin
      state_in         = state_ff;
      cmd.take         = req_valid && req_ready;
      cmd.start_packet = take_end && status.soh_end && status.crc_ok;
      cmd.load         = 1'b0;
      cmd.kind         = KIND_DATA;
      cmd.last         = 1'b0;
      cmd.clear_count  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (take_end) begin
               if (status.soh_end) begin
                  state_in = status.crc_ok ? S_DATA : S_NAK;
               end else if (status.eot) begin
                  state_in = S_EOT_ACK;
               end
            end
         end
         S_DATA: begin
            cmd.load = status.slot_free;
            if (status.slot_free && status.last_word) begin
               state_in = S_ACK;
            end
         end
         S_ACK: begin
            cmd.load = status.slot_free;
            cmd.kind = KIND_ACK;
            cmd.last = 1'b1;
            if (status.slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_NAK: begin
            cmd.load = status.slot_free;
            cmd.kind = KIND_NAK;
            cmd.last = 1'b1;
            if (status.slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_EOT_ACK: begin
            cmd.load = status.slot_free;
            cmd.kind = KIND_ACK;
            if (status.slot_free) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.load        = status.slot_free;
            cmd.kind        = KIND_DONE;
            cmd.last        = 1'b1;
            cmd.clear_count = status.slot_free;
            if (status.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.slot_free)
      else $error("result loaded while the output register is occupied");

   a_eot_ack_then_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EOT_ACK && cmd.load) |=> (state_ff == S_DONE))
      else $error("end-of-transfer ACK not followed by the done beat");

   a_data_ends_in_ack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA && cmd.load && status.last_word) |=> (state_ff == S_ACK))
      else $error("last data word not followed by ACK");

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && take_end && status.soh_end) |=> !req_ready)
      else $error("input taken while a full frame is answered");

endmodule

### src/xmodem_crc_packet_receiver.sv
// XMODEM-CRC frame receiver. The req channel carries one received byte per beat with a
// frame_end flag on the last byte of each frame; the rsp channel returns result beats.
// The csr port loads the destination base address; write it only while the block is idle.
// Bytes that do not end a frame are taken one per cycle with no result while the block is idle.
// A good 133-byte data frame yields 32 data-word beats with flash addresses and then an ACK
// beat; a CRC mismatch yields one NAK beat; a one-byte EOT frame yields ACK then done.
// Taking the frame's last byte moves the sequencer from idle to its answer state, which
// loads the first result into the output register; later results follow one per cycle
// while rsp_ready stays high. req_ready is low from the frame's last byte until its final
// result has been loaded into the output register; that last beat may still wait for
// rsp_ready while the next frame's bytes are already taken.
// When the receiver stalls, the output register holds its beat and the sequencer waits.
// Reset clears the frame state, packet count, base address and output valid; the payload
// buffer is not cleared, since every good frame rewrites it before it is read.
module xmodem_crc_packet_receiver
   import xcpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   xcpr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_data.frame_end),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   xcpr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule
